// ----- src/ezr_pkg.sv -----
// Shared types, widths and arithmetic helpers for the Euler zyx rotation matrix unit.
// Depends on nothing; every other source file imports it.
package ezr_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
    localparam int CORDIC_STEPS  = 30;
    localparam int ANG_SHIFT     = 32 - ANGLE_BITS;
    localparam int XW            = 33;   // Q2.30 sine and cosine
    localparam int ZW            = 34;   // residual angle, full turn is 2^32
    localparam int SW            = 35;   // sum of two Q30 products
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll;
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] yaw;
    } t_angles;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] r00;
        logic signed [OUT_WIDTH-1:0] r01;
        logic signed [OUT_WIDTH-1:0] r02;
        logic signed [OUT_WIDTH-1:0] r10;
        logic signed [OUT_WIDTH-1:0] r11;
        logic signed [OUT_WIDTH-1:0] r12;
        logic signed [OUT_WIDTH-1:0] r20;
        logic signed [OUT_WIDTH-1:0] r21;
        logic signed [OUT_WIDTH-1:0] r22;
    } t_matrix;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           q;
    } t_lane;

    // One CORDIC slot: lane 0 roll, lane 1 pitch, lane 2 yaw.
    typedef struct packed {
        logic        vld;
        t_lane [2:0] lane;
    } t_cstage;

    function automatic logic [31:0] atan_turn(input int step);
        logic [31:0] v;
        case (step)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
            27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q30 times Q30, rounded half up back to Q30.
    function automatic logic signed [XW-1:0] mul_q30(input logic signed [XW-1:0] a,
                                                     input logic signed [XW-1:0] b);
        logic signed [2*XW-1:0] p;
        p = a * b;
        p = p + (2*XW)'(64'sd1 <<< 29);
        return XW'(p >>> 30);
    endfunction

    // Q30 to the output format, rounded half up and clamped to plus or minus one.
    function automatic logic signed [OUT_WIDTH-1:0] to_output(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] lim;
        r   = (v + SW'(64'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
        lim = SW'(64'sd1 <<< OUT_FRAC_BITS);
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return OUT_WIDTH'(r);
    endfunction

endpackage

// ----- src/ezr_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation for all three angles, registered.
// Depends on ezr_pkg for the slot type and the arctangent table.
module ezr_cordic_cell
    import ezr_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cstage i_slot,
    output t_cstage o_slot
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(STEP));

    t_cstage r_slot;
    t_cstage n_slot;

    always_comb begin
        n_slot = i_slot;
        for (int k = 0; k < 3; k++) begin
            if (!i_slot.lane[k].z[ZW-1]) begin
                n_slot.lane[k].x = i_slot.lane[k].x - (i_slot.lane[k].y >>> STEP);
                n_slot.lane[k].y = i_slot.lane[k].y + (i_slot.lane[k].x >>> STEP);
                n_slot.lane[k].z = i_slot.lane[k].z - ATAN;
            end else begin
                n_slot.lane[k].x = i_slot.lane[k].x + (i_slot.lane[k].y >>> STEP);
                n_slot.lane[k].y = i_slot.lane[k].y - (i_slot.lane[k].x >>> STEP);
                n_slot.lane[k].z = i_slot.lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.vld <= 1'b0;
        end else if (i_en) begin
            r_slot.vld <= i_slot.vld;
        end
        if (i_en) begin
            r_slot.lane <= n_slot.lane;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- src/ezr_matrix_unit.sv -----
// Quadrant correction, the two product levels and output rounding of the matrix.
// Depends on ezr_pkg for types and the rounding multiply and output helpers.
module ezr_matrix_unit
    import ezr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cstage i_slot,
    output logic    o_valid,
    output t_matrix o_data
);

    logic signed [XW-1:0] n_c [3];
    logic signed [XW-1:0] n_s [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (i_slot.lane[k].q)
                2'd1: begin
                    n_c[k] = -i_slot.lane[k].y; n_s[k] = i_slot.lane[k].x;
                end
                2'd2: begin
                    n_c[k] = -i_slot.lane[k].x; n_s[k] = -i_slot.lane[k].y;
                end
                2'd3: begin
                    n_c[k] = i_slot.lane[k].y;  n_s[k] = -i_slot.lane[k].x;
                end
                default: begin
                    n_c[k] = i_slot.lane[k].x;  n_s[k] = i_slot.lane[k].y;
                end
            endcase
        end
    end

    // Stage Q: sine and cosine per angle.
    logic r_q_vld;
    logic signed [XW-1:0] r_rc, r_rs, r_pc, r_ps, r_yc, r_ys;
    // Stage M1: first-level products.
    logic r_m1_vld;
    logic signed [XW-1:0] r_ycpc, r_ysrc, r_ycps, r_ysrs, r_ycrc, r_yspc;
    logic signed [XW-1:0] r_rsps, r_psys, r_ycrs, r_pcrs, r_pcrc;
    logic signed [XW-1:0] r_m1_rs, r_m1_ps, r_m1_ys, r_m1_rc;
    // Stage M2: entries in Q30.
    logic r_m2_vld;
    logic signed [SW-1:0] r_e [9];
    // Output register.
    logic    r_o_vld;
    t_matrix r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld  <= 1'b0;
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (i_en) begin
            r_q_vld  <= i_slot.vld;
            r_m1_vld <= r_q_vld;
            r_m2_vld <= r_m1_vld;
            r_o_vld  <= r_m2_vld;
        end
        if (i_en) begin
            r_rc <= n_c[0]; r_rs <= n_s[0];
            r_pc <= n_c[1]; r_ps <= n_s[1];
            r_yc <= n_c[2]; r_ys <= n_s[2];

            r_ycpc <= mul_q30(r_yc, r_pc);
            r_ysrc <= mul_q30(r_ys, r_rc);
            r_ycps <= mul_q30(r_yc, r_ps);
            r_ysrs <= mul_q30(r_ys, r_rs);
            r_ycrc <= mul_q30(r_yc, r_rc);
            r_yspc <= mul_q30(r_ys, r_pc);
            r_rsps <= mul_q30(r_rs, r_ps);
            r_psys <= mul_q30(r_ps, r_ys);
            r_ycrs <= mul_q30(r_yc, r_rs);
            r_pcrs <= mul_q30(r_pc, r_rs);
            r_pcrc <= mul_q30(r_pc, r_rc);
            r_m1_rs <= r_rs; r_m1_ps <= r_ps; r_m1_ys <= r_ys; r_m1_rc <= r_rc;

            r_e[0] <= SW'(r_ycpc);
            r_e[1] <= SW'(mul_q30(r_ycps, r_m1_rs)) - SW'(r_ysrc);
            r_e[2] <= SW'(r_ysrs) + SW'(mul_q30(r_ycrc, r_m1_ps));
            r_e[3] <= SW'(r_yspc);
            r_e[4] <= SW'(r_ycrc) + SW'(mul_q30(r_rsps, r_m1_ys));
            r_e[5] <= SW'(mul_q30(r_psys, r_m1_rc)) - SW'(r_ycrs);
            r_e[6] <= -SW'(r_m1_ps);
            r_e[7] <= SW'(r_pcrs);
            r_e[8] <= SW'(r_pcrc);

            r_o_data.r00 <= to_output(r_e[0]);
            r_o_data.r01 <= to_output(r_e[1]);
            r_o_data.r02 <= to_output(r_e[2]);
            r_o_data.r10 <= to_output(r_e[3]);
            r_o_data.r11 <= to_output(r_e[4]);
            r_o_data.r12 <= to_output(r_e[5]);
            r_o_data.r20 <= to_output(r_e[6]);
            r_o_data.r21 <= to_output(r_e[7]);
            r_o_data.r22 <= to_output(r_e[8]);
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;

endmodule

// ----- src/euler_zyx_rotation_matrix_unit.sv -----
// Top level of the Euler zyx rotation matrix unit: angle folding, CORDIC chain, matrix unit.
// Depends on ezr_pkg, ezr_cordic_cell and ezr_matrix_unit.
//
// Usage. Each input transfer on the in channel (i_in_valid / o_in_ready, payload
// i_in_data) carries roll, pitch and yaw as 16-bit binary angles, where a full turn
// spans the whole code range. Each output transfer on the out channel (o_out_valid /
// i_out_ready, payload o_out_data) carries the nine entries of Rz(yaw)*Ry(pitch)*Rx(roll)
// in signed Q1.14, clamped to plus or minus one. Every input transfer gives exactly one
// output transfer, in order.
// On the way from input transfer to output valid, a fold register folds each angle into a
// quadrant and a residual, thirty cells of the CORDIC chain perform one
// micro-rotation each, then stage Q does quadrant correction, stages M1 and M2 form
// the products and an output register follows. Throughput is one item per cycle
// while the receiver does not stall; the whole pipeline moves together.
// When the receiver stalls with a result waiting, the pipeline freezes and o_in_ready
// drops; it rises again in the cycle the waiting result is taken, so no bubble is lost.
// Synchronous reset clears all valid flags; the data registers are not reset, and the
// block accepts input as soon as reset is released.
module euler_zyx_rotation_matrix_unit
    import ezr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_angles i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_matrix o_out_data
);

    // The whole pipeline advances whenever the output register is free or being drained.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Fold each angle to 32 bits: quadrant in the top two bits after rounding, residual
    // within plus or minus an eighth of a turn.
    function automatic t_lane fold(input logic [ANGLE_BITS-1:0] ang);
        logic [31:0] a;
        logic [31:0] sum;
        logic [31:0] ru;
        t_lane       l;
        a   = 32'(ang) << ANG_SHIFT;
        sum = a + 32'h2000_0000;
        ru  = a - {sum[31:30], 30'd0};
        l.q = sum[31:30];
        l.z = {{(ZW-32){ru[31]}}, ru};
        l.x = CORDIC_GAIN;
        l.y = '0;
        return l;
    endfunction

    t_cstage r_prep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else if (w_en) begin
            r_prep.vld <= i_in_valid;
        end
        if (w_en) begin
            r_prep.lane[0] <= fold(i_in_data.roll);
            r_prep.lane[1] <= fold(i_in_data.pitch);
            r_prep.lane[2] <= fold(i_in_data.yaw);
        end
    end

    // The chain: cell i applies micro-rotation i to all three angles.
    t_cstage w_chain [CORDIC_STEPS+1];
    assign w_chain[0] = r_prep;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        ezr_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_slot  (w_chain[g]),
            .o_slot  (w_chain[g+1])
        );
    end

    ezr_matrix_unit u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_slot  (w_chain[CORDIC_STEPS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_prep.vld)
        else $error("accepted item lost at pipeline entry");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

// ----- tb/euler_zyx_rotation_matrix_unit_checker.sv -----
// Checker for the Euler zyx rotation matrix unit: watches both channels, predicts each
// matrix from the accepted angles and compares field by field. Depends on ezr_pkg.
`timescale 1ns / 1ps
module euler_zyx_rotation_matrix_unit_checker
    import ezr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_ready,
    input  t_angles i_in_data,
    input  logic    i_out_valid,
    input  logic    i_out_ready,
    input  t_matrix i_out_data,
    output int      o_fail_count,
    output int      o_pending
);

    typedef logic signed [63:0] t_q30;

    t_matrix matrix_queue[$];
    logic [31:0] atan_tab[30];
    int fail_count = 0;

    initial begin
        atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                     32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                     32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
                     32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                     32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                     32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
    end

    assign o_pending    = matrix_queue.size();
    assign o_fail_count = fail_count;

    // Rounds half up after dropping n bits; arithmetic shift floors.
    function automatic t_q30 round_down(input t_q30 v, input int n);
        return (v + (t_q30'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_q30 qmul(input t_q30 a, input t_q30 b);
        return round_down(a * b, 30);
    endfunction

    // Sine and cosine of one binary angle in Q30.
    task automatic angle_trig(input logic [ANGLE_BITS-1:0] code, output t_q30 c,
                              output t_q30 s);
        logic [31:0] a;
        logic [1:0] quad;
        logic [31:0] resid;
        t_q30 x, y, z, dx, dy;
        a     = {code, {ANG_SHIFT{1'b0}}};
        quad  = 2'((a + 32'h20000000) >> 30);
        resid = a - ({30'd0, quad} << 30);
        z = t_q30'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= t_q30'(atan_tab[i]);
            end else begin
                x += dx; y -= dy; z += t_q30'(atan_tab[i]);
            end
        end
        case (quad)
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            2'd3: begin c = y; s = -x; end
            default: begin c = x; s = y; end
        endcase
    endtask

    function automatic logic [OUT_WIDTH-1:0] entry(input t_q30 v);
        t_q30 r;
        t_q30 lim;
        lim = t_q30'(1) <<< OUT_FRAC_BITS;
        r = round_down(v, 30 - OUT_FRAC_BITS);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r[OUT_WIDTH-1:0];
    endfunction

    task automatic predict_matrix(input t_angles ang, output t_matrix m);
        t_q30 cr, sr, cp, sp, cy, sy;
        angle_trig(ang.roll, cr, sr);
        angle_trig(ang.pitch, cp, sp);
        angle_trig(ang.yaw, cy, sy);
        m.r00 = entry(qmul(cy, cp));
        m.r01 = entry(-qmul(sy, cr) + qmul(qmul(cy, sp), sr));
        m.r02 = entry(qmul(sy, sr) + qmul(qmul(cy, cr), sp));
        m.r10 = entry(qmul(sy, cp));
        m.r11 = entry(qmul(cy, cr) + qmul(qmul(sr, sp), sy));
        m.r12 = entry(-qmul(cy, sr) + qmul(qmul(sp, sy), cr));
        m.r20 = entry(-sp);
        m.r21 = entry(qmul(cp, sr));
        m.r22 = entry(qmul(cp, cr));
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("Mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            predict_matrix(i_in_data, want);
            matrix_queue.push_back(want);
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (matrix_queue.size() == 0) begin
                report("unexpected transfer", 0, 0);
            end else begin
                want = matrix_queue.pop_front();
                if (i_out_data.r00 !== want.r00) report("r00", i_out_data.r00, want.r00);
                if (i_out_data.r01 !== want.r01) report("r01", i_out_data.r01, want.r01);
                if (i_out_data.r02 !== want.r02) report("r02", i_out_data.r02, want.r02);
                if (i_out_data.r10 !== want.r10) report("r10", i_out_data.r10, want.r10);
                if (i_out_data.r11 !== want.r11) report("r11", i_out_data.r11, want.r11);
                if (i_out_data.r12 !== want.r12) report("r12", i_out_data.r12, want.r12);
                if (i_out_data.r20 !== want.r20) report("r20", i_out_data.r20, want.r20);
                if (i_out_data.r21 !== want.r21) report("r21", i_out_data.r21, want.r21);
                if (i_out_data.r22 !== want.r22) report("r22", i_out_data.r22, want.r22);
            end
        end
    end

endmodule

// ----- tb/euler_zyx_rotation_matrix_unit_tb.sv -----
// Testbench top for the Euler zyx rotation matrix unit: clock, reset, stimulus and verdict.
// Depends on ezr_pkg, the block itself and euler_zyx_rotation_matrix_unit_checker.
`timescale 1ns / 1ps
module euler_zyx_rotation_matrix_unit_tb;
    import ezr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_angles in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_matrix out_data;
    int      fail_count;
    int      pending;
    int      cycle_count = 0;

    // Idle percentages for the sender and for the receiver, changed by phase.
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    always #5 i_clk = ~i_clk;

    euler_zyx_rotation_matrix_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    euler_zyx_rotation_matrix_unit_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // The receiver decides its readiness afresh at every edge.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The run is cut short at a generous cycle count, well beyond the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Presents one angle triple, after a random pause, and holds it until its transfer.
    // Valid drops only while the sender idles, so back-to-back transfers keep it high.
    task automatic send_angles(input t_angles ang);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= ang;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Mostly random codes; about one in eight lands on a quadrant edge or near one,
    // where the angle folding and the clamping are exercised hardest.
    function automatic logic [ANGLE_BITS-1:0] random_angle();
        logic [ANGLE_BITS-1:0] a;
        a = ANGLE_BITS'($urandom);
        if ($urandom_range(7) == 0) begin
            a = {a[ANGLE_BITS-1:ANGLE_BITS-2], {(ANGLE_BITS-2){1'b0}}}
                + ANGLE_BITS'($signed($urandom_range(6)) - 3);
        end
        return a;
    endfunction

    initial begin
        logic [ANGLE_BITS-1:0] corners[10];
        t_angles ang;
        corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                    16'h8001, 16'h2000, 16'hE000, 16'h0001, 16'hFFFF};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each corner angle on each axis in turn, then gimbal lock and pi.
        for (int i = 0; i < 10; i++) begin
            ang.roll = corners[i]; ang.pitch = corners[(i + 3) % 10];
            ang.yaw = corners[(i + 7) % 10];
            send_angles(ang);
        end
        ang = '{16'h1234, 16'h4000, 16'h5678}; send_angles(ang);
        ang = '{16'hABCD, 16'hC000, 16'h2222}; send_angles(ang);
        ang = '{16'h8000, 16'h8000, 16'h8000}; send_angles(ang);
        ang = '{16'h7FFF, 16'h7FFF, 16'h7FFF}; send_angles(ang);
        ang = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; send_angles(ang);
        ang = '{16'h5555, 16'hAAAA, 16'h5555}; send_angles(ang);
        in_valid <= 1'b0;

        // Hold off until every expected matrix has arrived.
        while (pending != 0) @(posedge i_clk);

        // Random phases: free flow, idle sender, stalling receiver, then both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < 308; n++) begin
                ang.roll = random_angle(); ang.pitch = random_angle();
                ang.yaw = random_angle();
                send_angles(ang);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
